@@ hw/rtl/mqtt_pp_pkg.sv @@
package mqtt_pp_pkg;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_TOPLEN  = 3'd2,
      PH_TOPIC   = 3'd3,
      PH_IDENT   = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_ERROR   = 3'd6
   } phase_type;

   // byte class tags on the result channel
   localparam logic [2:0] CLS_HEADER  = 3'd0;
   localparam logic [2:0] CLS_LENGTH  = 3'd1;
   localparam logic [2:0] CLS_TOPLEN  = 3'd2;
   localparam logic [2:0] CLS_TOPIC   = 3'd3;
   localparam logic [2:0] CLS_IDENT   = 3'd4;
   localparam logic [2:0] CLS_PAYLOAD = 3'd5;
   localparam logic [2:0] CLS_DISCARD = 3'd6;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_PROTOCOL = 2'd2;

   localparam logic [3:0]  PUBLISH_TYPE = 4'h3;
   localparam logic [2:0]  LEN_BYTES_MAX = 3'd4;
   localparam logic [27:0] COUNT_MAX = 28'hFFF_FFFF;
   localparam int          RSP_DATA_W = 104;

   typedef struct packed {
      logic       in_last;
      logic [7:0] in_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  data_out;
      logic        done_res;
      logic [1:0]  status;
      logic        dup_flag;
      logic [1:0]  qos_level;
      logic        retain_flag;
      logic [15:0] topic_length;
      logic [15:0] packet_ident;
      logic [27:0] remain_len;
      logic [27:0] payload_length;
   } rsp_word_type;

endpackage

@@ hw/rtl/mqtt_pp_in_stage.sv @@
module mqtt_pp_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  mqtt_pp_pkg::req_word_type  in_word,
   input  logic                       advance,
   output logic                       held_valid,
   output mqtt_pp_pkg::req_word_type  held_word
);

   logic                      valid_ff;
   logic                      valid_in;
   mqtt_pp_pkg::req_word_type word_ff;

   // take a new word when empty or when the held word moves on this cycle
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule

@@ hw/rtl/mqtt_pp_parse.sv @@
module mqtt_pp_parse (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  mqtt_pp_pkg::req_word_type  word,
   output mqtt_pp_pkg::rsp_word_type  result
);

   mqtt_pp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  flags_ff, flags_in;
   logic [27:0] len_acc_ff, len_acc_in;
   logic [2:0]  len_cnt_ff, len_cnt_in;
   logic [15:0] top_len_ff, top_len_in;
   logic [15:0] top_cnt_ff, top_cnt_in;
   logic [15:0] ident_ff, ident_in;
   logic [27:0] pay_cnt_ff, pay_cnt_in;
   logic [1:0]  err_ff, err_in;
   logic        half_ff, half_in;

   mqtt_pp_pkg::phase_type after_topic;
   logic [7:0]  b;
   logic [2:0]  cls;
   logic [27:0] len_part;
   logic [1:0]  st;

   assign b = word.in_byte;
   assign after_topic = (flags_ff[2:1] != 2'd0) ? mqtt_pp_pkg::PH_IDENT
                                                : mqtt_pp_pkg::PH_PAYLOAD;

   always_comb begin
      unique case (len_cnt_ff[1:0])
         2'd0: len_part = {21'd0, b[6:0]};
         2'd1: len_part = {14'd0, b[6:0], 7'd0};
         2'd2: len_part = {7'd0, b[6:0], 14'd0};
         2'd3: len_part = {b[6:0], 21'd0};
         default: len_part = 28'd0;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      flags_in   = flags_ff;
      len_acc_in = len_acc_ff;
      len_cnt_in = len_cnt_ff;
      top_len_in = top_len_ff;
      top_cnt_in = top_cnt_ff;
      ident_in   = ident_ff;
      pay_cnt_in = pay_cnt_ff;
      err_in     = err_ff;
      half_in    = half_ff;
      cls        = mqtt_pp_pkg::CLS_DISCARD;

      unique case (phase_ff)
         mqtt_pp_pkg::PH_HEADER: begin
            cls = mqtt_pp_pkg::CLS_HEADER;
            if (b[7:4] != mqtt_pp_pkg::PUBLISH_TYPE) begin
               err_in   = mqtt_pp_pkg::ST_PROTOCOL;
               phase_in = mqtt_pp_pkg::PH_ERROR;
            end else begin
               flags_in = b[3:0];
               phase_in = mqtt_pp_pkg::PH_LENGTH;
            end
         end
         mqtt_pp_pkg::PH_LENGTH: begin
            cls = mqtt_pp_pkg::CLS_LENGTH;
            if (!len_cnt_ff[2]) begin
               len_acc_in = len_acc_ff | len_part;
            end
            len_cnt_in = len_cnt_ff + 3'd1;
            if (b[7]) begin
               // a continuation on the fourth length byte is illegal
               if (len_cnt_in >= mqtt_pp_pkg::LEN_BYTES_MAX) begin
                  err_in   = mqtt_pp_pkg::ST_PROTOCOL;
                  phase_in = mqtt_pp_pkg::PH_ERROR;
               end
            end else begin
               phase_in = mqtt_pp_pkg::PH_TOPLEN;
            end
         end
         mqtt_pp_pkg::PH_TOPLEN: begin
            cls = mqtt_pp_pkg::CLS_TOPLEN;
            if (!half_ff) begin
               top_len_in = {b, 8'd0};
               half_in    = 1'b1;
            end else begin
               top_len_in = {top_len_ff[15:8], top_len_ff[7:0] | b};
               half_in    = 1'b0;
               top_cnt_in = 16'd0;
               phase_in   = (top_len_in == 16'd0) ? after_topic
                                                  : mqtt_pp_pkg::PH_TOPIC;
            end
         end
         mqtt_pp_pkg::PH_TOPIC: begin
            cls = mqtt_pp_pkg::CLS_TOPIC;
            top_cnt_in = top_cnt_ff + 16'd1;
            if (top_cnt_in >= top_len_ff) begin
               phase_in = after_topic;
            end
         end
         mqtt_pp_pkg::PH_IDENT: begin
            cls = mqtt_pp_pkg::CLS_IDENT;
            if (!half_ff) begin
               ident_in = {b, 8'd0};
               half_in  = 1'b1;
            end else begin
               ident_in = {ident_ff[15:8], ident_ff[7:0] | b};
               half_in  = 1'b0;
               phase_in = mqtt_pp_pkg::PH_PAYLOAD;
            end
         end
         mqtt_pp_pkg::PH_PAYLOAD: begin
            cls = mqtt_pp_pkg::CLS_PAYLOAD;
            if (pay_cnt_ff < mqtt_pp_pkg::COUNT_MAX) begin
               pay_cnt_in = pay_cnt_ff + 28'd1;
            end
         end
         default: begin
            cls      = mqtt_pp_pkg::CLS_DISCARD;
            phase_in = mqtt_pp_pkg::PH_ERROR;
         end
      endcase
   end

   always_comb begin
      priority if (phase_ff == mqtt_pp_pkg::PH_HEADER) begin
         st = mqtt_pp_pkg::ST_INVALID;
      end else if (err_in != mqtt_pp_pkg::ST_OK) begin
         st = err_in;
      end else if (phase_in == mqtt_pp_pkg::PH_PAYLOAD) begin
         st = mqtt_pp_pkg::ST_OK;
      end else begin
         st = mqtt_pp_pkg::ST_INVALID;
      end
   end

   always_comb begin
      result            = '0;
      result.byte_class = cls;
      result.data_out   = b;
      if (word.in_last) begin
         result.done_res       = 1'b1;
         result.status         = st;
         result.dup_flag       = flags_in[3];
         result.qos_level      = flags_in[2:1];
         result.retain_flag    = flags_in[0];
         result.topic_length   = top_len_in;
         result.packet_ident   = (flags_in[2:1] != 2'd0) ? ident_in : 16'd0;
         result.remain_len     = len_acc_in;
         result.payload_length = pay_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && word.in_last)) begin
         phase_ff   <= mqtt_pp_pkg::PH_HEADER;
         flags_ff   <= 4'd0;
         len_acc_ff <= 28'd0;
         len_cnt_ff <= 3'd0;
         top_len_ff <= 16'd0;
         top_cnt_ff <= 16'd0;
         ident_ff   <= 16'd0;
         pay_cnt_ff <= 28'd0;
         err_ff     <= 2'd0;
         half_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         flags_ff   <= flags_in;
         len_acc_ff <= len_acc_in;
         len_cnt_ff <= len_cnt_in;
         top_len_ff <= top_len_in;
         top_cnt_ff <= top_cnt_in;
         ident_ff   <= ident_in;
         pay_cnt_ff <= pay_cnt_in;
         err_ff     <= err_in;
         half_ff    <= half_in;
      end
   end

endmodule

@@ hw/rtl/mqtt_pp_out_stage.sv @@
module mqtt_pp_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   output logic                       load_ready,
   input  mqtt_pp_pkg::rsp_word_type  load_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output mqtt_pp_pkg::rsp_word_type  out_word
);

   logic                      valid_ff;
   logic                      valid_in;
   mqtt_pp_pkg::rsp_word_type word_ff;

   // free when empty or when the held word is taken this cycle
   assign load_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load_ready) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_ready) begin
         word_ff <= load_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ hw/rtl/mqtt_publish_packet_parser_core.sv @@
// A byte accepted into the input register goes on through the result register to the
// result channel. Throughput: one byte per cycle while rsp_tready holds; each byte passes
// the input register, one short parse update of the header/length/topic/ident/payload
// state, and the result register. Reset (synchronous, active high) empties both
// registers and returns the parser to expect a fixed header, as does every last byte.
module mqtt_publish_packet_parser_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] in_byte
   input  logic                            req_tlast,  // in_last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] data_out, [9:8] status, [10] dup_flag, [12:11] qos_level,
   // [13] retain_flag, [29:14] topic_length, [45:30] packet_ident,
   // [73:46] remain_len, [101:74] payload_length, [103:102] zero
   output logic [mqtt_pp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]                      rsp_tuser,  // [2:0] byte_class
   output logic                            rsp_tlast   // done_res
);

   mqtt_pp_pkg::req_word_type req_word;
   mqtt_pp_pkg::req_word_type held_word;
   mqtt_pp_pkg::rsp_word_type parsed;
   mqtt_pp_pkg::rsp_word_type rsp_word;
   logic held_valid;
   logic out_free;
   logic advance;

   assign req_word.in_byte = req_tdata;
   assign req_word.in_last = req_tlast;

   // move a word from the input register into the result register
   assign advance = held_valid && out_free;

   mqtt_pp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_word    (req_word),
      .advance    (advance),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   mqtt_pp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (held_word),
      .result  (parsed)
   );

   mqtt_pp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (held_valid),
      .load_ready (out_free),
      .load_word  (parsed),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (rsp_word)
   );

   assign rsp_tdata = {2'b00,
                       rsp_word.payload_length,
                       rsp_word.remain_len,
                       rsp_word.packet_ident,
                       rsp_word.topic_length,
                       rsp_word.retain_flag,
                       rsp_word.qos_level,
                       rsp_word.dup_flag,
                       rsp_word.status,
                       rsp_word.data_out};
   assign rsp_tuser = rsp_word.byte_class;
   assign rsp_tlast = rsp_word.done_res;

endmodule
